[rtl/ipv4hb_pkg.sv]
// Shared constants and types for the IPv4 header builder.
`timescale 1ns / 1ps
`default_nettype none

package ipv4hb_pkg;

    // Fixed header fields.
    localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
    localparam logic [15:0] DONT_FRAG    = 16'h4000;
    localparam logic [7:0]  TIME_TO_LIVE = 8'd64;
    localparam logic [15:0] HDR_BYTES    = 16'd20;
    localparam logic [15:0] ID_RESET     = 16'd1;

    // Result words per request.
    localparam int          HDR_WORDS    = 5;
    localparam int          CNT_W        = $clog2(HDR_WORDS + 1);

    // Width of the unfolded ones-complement sum (up to nine 16-bit terms).
    localparam int          SUM_W        = 20;

    // Configuration register indexes.
    localparam logic [1:0]  REG_OWN      = 2'd0;
    localparam logic [1:0]  REG_GATEWAY  = 2'd1;
    localparam logic [1:0]  REG_MASK     = 2'd2;

    // Send status codes.
    localparam logic        STATUS_OK      = 1'b0;
    localparam logic        STATUS_NO_ADDR = 1'b1;

    typedef logic [31:0] t_word;
    typedef logic [SUM_W-1:0] t_sum;

endpackage

`default_nettype wire

[rtl/ipv4_header_builder.sv]
// IPv4 header builder: header words, checksum and next-hop selection.
// A request is registered in the request stage and then loaded into the output stage.
// Throughput: one word per cycle on the result side while i_m_tready is high; a
// request yields five words, or one word when it finds the own address unset; the
// five-word output shift register is refilled as its last word leaves.
// Reset (synchronous, active low) clears the configuration registers, sets the
// identification counter to one, and empties both stages; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_header_builder
    import ipv4hb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [55:0] i_s_tdata,  // dest_address, protocol_number, payload_length
    // Result stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [63:0] o_m_tdata,  // header_word, next_hop
    output      logic        o_m_tlast,  // last_word
    output      logic [0:0]  o_m_tuser,  // send_status
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    // Configuration registers.
    t_word r_own;
    t_word r_gateway;
    t_word r_mask;

    // Request stage.
    logic        r_req_valid;
    t_word       r_req_dest;
    logic [7:0]  r_req_proto;
    logic [15:0] r_req_total;
    t_sum        r_req_part;
    t_word       r_req_hop;
    logic        r_req_err;

    // Result stage: shift register of header words.
    t_word           r_word [HDR_WORDS];
    t_word           r_hop;
    logic            r_err;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]     r_id;

    // Input field split.
    t_word       s_dest;
    logic [7:0]  s_proto;
    logic [15:0] s_plen;
    logic [15:0] s_total;
    t_sum        s_part;

    logic        s_acc;
    logic        m_acc;
    logic        load;
    logic        cfg_wr;

    t_sum        sum_all;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] csum;

    assign s_dest  = i_s_tdata[31:0];
    assign s_proto = i_s_tdata[39:32];
    assign s_plen  = i_s_tdata[55:40];

    // Handshakes.
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign load       = r_req_valid &&
                        ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && m_acc));
    assign o_s_tready = !r_req_valid || load;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // APB writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_OWN:     prdata = r_own;
            REG_GATEWAY: prdata = r_gateway;
            REG_MASK:    prdata = r_mask;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own     <= '0;
            r_gateway <= '0;
            r_mask    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_OWN:     r_own     <= pwdata;
                REG_GATEWAY: r_gateway <= pwdata;
                REG_MASK:    r_mask    <= pwdata;
                default:     ;
            endcase
        end
    end

    // Total length wraps at 16 bits; the partial checksum covers every half
    // except the identification, which is added when the header is built.
    assign s_total = s_plen + HDR_BYTES;
    assign s_part  = SUM_W'(VER_IHL_TOS) + SUM_W'(s_total) + SUM_W'(DONT_FRAG)
                   + SUM_W'({TIME_TO_LIVE, s_proto})
                   + SUM_W'(r_own[31:16]) + SUM_W'(r_own[15:0])
                   + SUM_W'(s_dest[31:16]) + SUM_W'(s_dest[15:0]);

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (s_acc) begin
            r_req_valid <= 1'b1;
        end else if (load) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req_dest  <= s_dest;
            r_req_proto <= s_proto;
            r_req_total <= s_total;
            r_req_part  <= s_part;
            r_req_err   <= (r_own == '0);
            r_req_hop   <= ((s_dest & r_mask) == (r_own & r_mask)) ? s_dest : r_gateway;
        end
    end

    // Checksum: add identification, fold twice, invert.
    assign sum_all = r_req_part + SUM_W'(r_id);
    assign fold1   = 17'(sum_all[15:0]) + 17'(sum_all[SUM_W-1:16]);
    assign fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);
    assign csum    = ~fold2[15:0];

    // Identification counter advances once per emitted header.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= ID_RESET;
        end else if (load && !r_req_err) begin
            r_id <= r_id + 16'd1;
        end
    end

    // Word count of the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= r_req_err ? CNT_W'(1) : CNT_W'(HDR_WORDS);
        end else if (m_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Header words load in parallel and shift toward the output.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_err <= r_req_err;
            if (r_req_err) begin
                r_hop    <= '0;
                r_word[0] <= '0;
            end else begin
                r_hop     <= r_req_hop;
                r_word[0] <= {VER_IHL_TOS, r_req_total};
                r_word[1] <= {r_id, DONT_FRAG};
                r_word[2] <= {TIME_TO_LIVE, r_req_proto, csum};
                r_word[3] <= r_own;
                r_word[4] <= r_req_dest;
            end
        end else if (m_acc) begin
            for (int i = 0; i < HDR_WORDS - 1; i++) begin
                r_word[i] <= r_word[i+1];
            end
        end
    end

    // Result outputs.
    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tlast  = (r_cnt == CNT_W'(1));
    assign o_m_tdata  = {r_hop, r_word[0]};
    assign o_m_tuser  = r_err ? STATUS_NO_ADDR : STATUS_OK;

    // The word count never exceeds one header.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(HDR_WORDS))
        else $error("word count out of range");

    // An error result is a single, final word.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == STATUS_NO_ADDR)) |-> o_m_tlast)
        else $error("error result is not the last word");

    // A good header loads five words.
    a_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_req_err) |=> (r_cnt == CNT_W'(HDR_WORDS)))
        else $error("header load did not set five words");

    // Identification moves only when a good header is built.
    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!load || r_req_err) |=> $stable(r_id))
        else $error("identification changed without a header");

endmodule

`default_nettype wire
